/* sv/assert_macros.svh */
// assertion macros used by the sm2_order_modular_alu rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define SM2O_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication
`define SM2O_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* sv/sm2o_pkg.sv */
// constants and types of the sm2 order arithmetic unit
package sm2o_pkg;

  // curve order n
  localparam logic [255:0] N = 256'hFFFFFFFE_FFFFFFFF_FFFFFFFF_FFFFFFFF_7203DF6B_21C6052B_53BBF409_39D54123;
  // 2^256 - n
  localparam logic [255:0] COMP_N =
    256'h00000001_00000000_00000000_00000000_8DFC2094_DE39FAD4_AC440BF6_C62ABEDD;
  // floor(2^512 / n) - 2^256
  localparam logic [255:0] MU_LOW =
    256'h00000001_00000001_00000001_00000001_8DFC2096_FA323C01_12AC6361_F15149A0;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_SUB = 2'd1,
    REQ_MUL = 2'd2,
    REQ_INV = 2'd3
  } req_e;

  typedef struct packed {
    logic start;
    logic nine;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

/* sv/sm2o_mul.sv */
// limb-serial multiplier: 32x32 multiply-accumulate over a rotating window
module sm2o_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sm2o_pkg::mul_ctrl_t  ctrl_i,
  input  logic [287:0]         op_a_i,
  input  logic [255:0]         op_b_i,
  output sm2o_pkg::mul_stat_t  stat_o,
  output logic [543:0]         prod_o
);

  logic         busy_q, busy_d, done_q, done_d;
  logic         nine_q;
  logic [3:0]   row_q, col_q;
  logic [287:0] a_q, low_q;
  logic [255:0] b_q, win_q;
  logic [31:0]  c_q;
  logic [63:0]  mprod, t;
  logic         last_row;

  // one limb product plus window limb and carry
  assign mprod    = {32'h0, a_q[31:0]} * {32'h0, b_q[31:0]};
  assign t        = mprod + {32'h0, win_q[31:0]} + {32'h0, c_q};
  assign last_row = (row_q == (nine_q ? 4'd8 : 4'd7));

  // control sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (!busy_q && ctrl_i.start) begin
      busy_d = 1'b1;
    end else if (busy_q && col_q == 4'd8 && last_row) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath: rows of eight products, then a retire step that shifts out a limb
  always_ff @(posedge clk_i) begin
    if (!busy_q && ctrl_i.start) begin
      a_q    <= op_a_i;
      b_q    <= op_b_i;
      win_q  <= '0;
      low_q  <= '0;
      c_q    <= '0;
      row_q  <= '0;
      col_q  <= '0;
      nine_q <= ctrl_i.nine;
    end else if (busy_q) begin
      if (col_q != 4'd8) begin
        win_q <= {t[31:0], win_q[255:32]};
        b_q   <= {b_q[31:0], b_q[255:32]};
        c_q   <= t[63:32];
        col_q <= col_q + 4'd1;
      end else begin
        low_q <= {win_q[31:0], low_q[287:32]};
        win_q <= {c_q, win_q[255:32]};
        c_q   <= '0;
        col_q <= '0;
        a_q   <= {32'h0, a_q[287:32]};
        row_q <= row_q + 4'd1;
      end
    end
  end

  assign prod_o      = nine_q ? {win_q, low_q} : {32'h0, win_q, low_q[287:32]};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* sv/sm2_order_modular_alu.sv */
// modular add, subtract, multiply and inverse modulo the sm2 order
//
// channel  dir  tdata                                    tuser
// s_axis   in   a_word0..a_word3, b_word0..b_word3       req_type
// m_axis   out  res_word0..res_word3                     zero_inverse_error
//
// one word in flight; s_axis_tready is high only while idle; reset clears only
// the sequencer and multiplier control; add steps through S_ADD1 and S_ADD2;
// subtract through S_MS1, then S_MS2 and S_MS3 on a borrow; multiply runs three
// passes of the 32x32 multiplier (8, 8 and 9 rows) plus Barrett correction;
// inverse alternates halvings and subtractions; the result word holds until taken
`include "assert_macros.svh"
module sm2_order_modular_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_word0, a_word1, a_word2, a_word3, b_word0, b_word1, b_word2, b_word3
  input  logic [511:0] s_axis_tdata,
  // req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_word0, res_word1, res_word2, res_word3
  output logic [255:0] m_axis_tdata,
  // zero_inverse_error
  output logic [0:0]   m_axis_tuser
);

  typedef enum logic [21:0] {
    S_IDLE = 22'h000001, S_ADD1 = 22'h000002, S_ADD2 = 22'h000004,
    S_MS1  = 22'h000008, S_MS2  = 22'h000010, S_MS3  = 22'h000020,
    S_M1   = 22'h000040, S_M1W  = 22'h000080, S_M2   = 22'h000100,
    S_M2W  = 22'h000200, S_Q3   = 22'h000400, S_M3   = 22'h000800,
    S_M3W  = 22'h001000, S_REM  = 22'h002000, S_CORR = 22'h004000,
    S_H1   = 22'h008000, S_H2   = 22'h010000, S_CHK1 = 22'h020000,
    S_CMP  = 22'h040000, S_XSUB = 22'h080000, S_CHK2 = 22'h100000,
    S_OUT  = 22'h200000
  } state_e;

  state_e state_q, state_d;

  logic [255:0] a_in, b_in;
  logic [259:0] u_q, v_q;
  logic [255:0] x1_q, y1_q, x2_q, y2_q, xlo_q, xhi_q, res_q;
  logic [256:0] q3_q;
  logic         cy_q, sel_q, inv_q, err_q;

  logic [259:0] ax, ay;
  logic         asub;
  logic [260:0] s;
  logic         ge;

  sm2o_pkg::mul_ctrl_t mul_ctrl;
  sm2o_pkg::mul_stat_t mul_stat;
  logic [287:0]        mul_a;
  logic [255:0]        mul_b;
  logic [543:0]        prod;

  assign a_in = {s_axis_tdata[63:0], s_axis_tdata[127:64],
                 s_axis_tdata[191:128], s_axis_tdata[255:192]};
  assign b_in = {s_axis_tdata[319:256], s_axis_tdata[383:320],
                 s_axis_tdata[447:384], s_axis_tdata[511:448]};

  // shared adder operand selection
  always_comb begin
    ax   = u_q;
    ay   = v_q;
    asub = 1'b0;
    case (state_q)
      S_ADD2: begin
        ay   = cy_q ? {4'h0, sm2o_pkg::COMP_N} : {4'h0, sm2o_pkg::N};
        asub = !cy_q;
      end
      S_MS1:  asub = 1'b1;
      S_MS2: begin
        ax   = {4'h0, sm2o_pkg::N};
        asub = 1'b1;
      end
      S_Q3: begin
        ax = {4'h0, xhi_q};
        ay = {4'h0, prod[511:256]};
      end
      S_REM: begin
        ax   = {xhi_q[3:0], xlo_q};
        ay   = prod[259:0];
        asub = 1'b1;
      end
      S_CORR: begin
        ay   = {4'h0, sm2o_pkg::N};
        asub = 1'b1;
      end
      S_H1: begin
        ax = {4'h0, y1_q};
        ay = {4'h0, sm2o_pkg::N};
      end
      S_H2: begin
        ax = {4'h0, y2_q};
        ay = {4'h0, sm2o_pkg::N};
      end
      S_CMP: begin
        ax   = {4'h0, x1_q};
        ay   = {4'h0, x2_q};
        asub = 1'b1;
      end
      S_XSUB: begin
        ax   = {4'h0, x2_q};
        ay   = {4'h0, x1_q};
        asub = 1'b1;
      end
      default: ;
    endcase
  end

  assign s  = {1'b0, ax} + {1'b0, (asub ? ~ay : ay)} + {260'h0, asub};
  assign ge = s[260];

  // multiplier operands
  always_comb begin
    mul_a = {32'h0, u_q[255:0]};
    mul_b = v_q[255:0];
    case (state_q)
      S_M2: begin
        mul_a = {32'h0, xhi_q};
        mul_b = sm2o_pkg::MU_LOW;
      end
      S_M3: begin
        mul_a = {31'h0, q3_q};
        mul_b = sm2o_pkg::N;
      end
      default: ;
    endcase
  end

  assign mul_ctrl.start = (state_q == S_M1) || (state_q == S_M2) || (state_q == S_M3);
  assign mul_ctrl.nine  = (state_q == S_M3);

  sm2o_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (sm2o_pkg::req_e'(s_axis_tuser))
            sm2o_pkg::REQ_ADD: state_d = S_ADD1;
            sm2o_pkg::REQ_SUB: state_d = S_MS1;
            sm2o_pkg::REQ_MUL: state_d = S_M1;
            default: begin
              state_d = ((a_in == '0) || (a_in == sm2o_pkg::N)) ? S_OUT : S_H1;
            end
          endcase
        end
      end
      S_ADD1: state_d = S_ADD2;
      S_ADD2: state_d = S_OUT;
      S_MS1:  state_d = ge ? (inv_q ? S_CHK2 : S_OUT) : S_MS2;
      S_MS2:  state_d = S_MS3;
      S_MS3:  state_d = inv_q ? S_CHK2 : S_OUT;
      S_M1:   state_d = S_M1W;
      S_M1W:  if (mul_stat.done) state_d = S_M2;
      S_M2:   state_d = S_M2W;
      S_M2W:  if (mul_stat.done) state_d = S_Q3;
      S_Q3:   state_d = S_M3;
      S_M3:   state_d = S_M3W;
      S_M3W:  if (mul_stat.done) state_d = S_REM;
      S_REM:  state_d = S_CORR;
      S_CORR: if (!ge) state_d = S_OUT;
      S_H1:   if (x1_q[0]) state_d = S_H2;
      S_H2:   if (x2_q[0]) state_d = S_CHK1;
      S_CHK1: begin
        if ((x1_q == 256'd1) || (x2_q == 256'd1)) state_d = S_OUT;
        else state_d = S_CMP;
      end
      S_CMP:  state_d = (ge && s[255:0] != '0) ? S_MS1 : S_XSUB;
      S_XSUB: state_d = S_MS1;
      S_CHK2: begin
        if ((x1_q == 256'd1) || (x2_q == 256'd1)) state_d = S_OUT;
        else state_d = S_H1;
      end
      S_OUT:  if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          u_q   <= {4'h0, a_in};
          v_q   <= {4'h0, b_in};
          inv_q <= (s_axis_tuser == sm2o_pkg::REQ_INV);
          err_q <= (s_axis_tuser == sm2o_pkg::REQ_INV) &&
                   ((a_in == '0) || (a_in == sm2o_pkg::N));
          res_q <= '0;
          x1_q  <= a_in;
          y1_q  <= 256'd1;
          x2_q  <= sm2o_pkg::N;
          y2_q  <= '0;
        end
      end
      S_ADD1: begin
        u_q  <= {4'h0, s[255:0]};
        cy_q <= s[256];
      end
      S_ADD2: res_q <= (cy_q || ge) ? s[255:0] : u_q[255:0];
      S_MS1: begin
        if (ge) begin
          if (!inv_q) res_q <= s[255:0];
          else if (sel_q) y2_q <= s[255:0];
          else y1_q <= s[255:0];
        end
      end
      S_MS2: v_q <= {4'h0, s[255:0]};
      S_MS3: begin
        if (!inv_q) res_q <= s[255:0];
        else if (sel_q) y2_q <= s[255:0];
        else y1_q <= s[255:0];
      end
      S_M1W: begin
        if (mul_stat.done) begin
          xlo_q <= prod[255:0];
          xhi_q <= prod[511:256];
        end
      end
      S_Q3:   q3_q <= s[256:0];
      S_REM:  u_q <= s[259:0];
      S_CORR: begin
        if (ge) u_q <= s[259:0];
        else res_q <= u_q[255:0];
      end
      S_H1: begin
        if (!x1_q[0]) begin
          x1_q <= {1'b0, x1_q[255:1]};
          y1_q <= y1_q[0] ? s[256:1] : {1'b0, y1_q[255:1]};
        end
      end
      S_H2: begin
        if (!x2_q[0]) begin
          x2_q <= {1'b0, x2_q[255:1]};
          y2_q <= y2_q[0] ? s[256:1] : {1'b0, y2_q[255:1]};
        end
      end
      S_CHK1, S_CHK2: begin
        if (x1_q == 256'd1) res_q <= y1_q;
        else if (x2_q == 256'd1) res_q <= y2_q;
      end
      S_CMP: begin
        if (ge && s[255:0] != '0) begin
          x1_q  <= s[255:0];
          sel_q <= 1'b0;
          u_q   <= {4'h0, y1_q};
          v_q   <= {4'h0, y2_q};
        end
      end
      S_XSUB: begin
        x2_q  <= s[255:0];
        sel_q <= 1'b1;
        u_q   <= {4'h0, y2_q};
        v_q   <= {4'h0, y1_q};
      end
      default: ;
    endcase
  end

  // output word
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {res_q[63:0], res_q[127:64], res_q[191:128], res_q[255:192]};
  assign m_axis_tuser  = err_q;

  // checks
  `SM2O_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
  `SM2O_ASSERT(a_err_zero, !(m_axis_tvalid && m_axis_tuser[0]) || (m_axis_tdata == '0),
               "error with nonzero result")
  `SM2O_ASSERT(a_mul_start, !(mul_ctrl.start && mul_stat.busy),
               "multiplier restarted while busy")
  `SM2O_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                    "ready right after accept")

endmodule
